@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the Sobel edge block.
// Depends on nothing; a module that asserts names its clock clk_i and reset rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Generic clocked assertion with an active-low reset that disables checking.
`define SEM_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Short form that uses the usual clock and reset names of this project.
`define SEM_ASSERT(lbl, prop, msg) `SEM_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`endif

@@ hw/rtl/sem_pkg.sv @@
// Types, constants and helper functions of the Sobel edge magnitude block.
// Depends on nothing; used by the front end, the back end and the top of the block.
package sem_pkg;

  localparam int unsigned NUM_CH         = 3;
  localparam int unsigned SMP_W          = 8;
  localparam int unsigned PIX_W          = NUM_CH * SMP_W;
  localparam int unsigned GRAD_W         = 11;
  localparam int unsigned ROW_W          = 12;
  localparam int unsigned COL_W          = 10;
  localparam int unsigned LW_W           = 11;
  localparam int unsigned FH_W           = 13;
  localparam int unsigned CFG_DATA_W     = 13;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned DEF_MAX_LINE   = 1024;
  localparam int unsigned DEF_CHANNELS   = 3;
  localparam int unsigned HEIGHT_LIMIT   = 4096;
  localparam int unsigned Q_DEPTH        = 8;
  localparam int unsigned O_DEPTH        = 8;
  localparam logic [LW_W-1:0] LW_RESET   = LW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET   = FH_W'(480);
  localparam logic [SMP_W-1:0] EDGE_MAX  = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [ROW_W-1:0]                    row;
    logic [COL_W-1:0]                    col;
    logic                                done;
    logic [NUM_CH-1:0][GRAD_W-1:0]       gx;
    logic [NUM_CH-1:0][GRAD_W-1:0]       gy;
  } grad_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]                    row;
    logic [COL_W-1:0]                    col;
    logic                                done;
    logic [NUM_CH-1:0][SMP_W-1:0]        mag;
  } edge_item_t;

  // One bit of a restoring integer square root.
  function automatic logic [7:0] isq_step(input logic [7:0] r, input logic [7:0] b,
                                          input logic [15:0] v);
    logic [7:0] t;
    t = r | b;
    return ((16'(t) * 16'(t)) <= v) ? t : r;
  endfunction

endpackage

@@ hw/rtl/sem_fifo.sv @@
// Small register-based first-in first-out queue.
// Depends on nothing; the front queue and the result queue are instances of it.
module sem_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic                         empty_o,
  output logic                         full_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0]           mem_q [DEPTH];
  logic [PW-1:0]              wr_q, wr_d, rd_q, rd_d;
  logic [$clog2(DEPTH+1)-1:0] cnt_q, cnt_d;
  logic                       do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == ($clog2(DEPTH+1))'(DEPTH));
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/sem_front.sv @@
// Front end: raster counters, line memory, 3x3 windows and Sobel gradients.
// Depends on sem_pkg; feeds the gradient queue under a credit taken from its fill level.
module sem_front
  import sem_pkg::*;
#(
  parameter int unsigned MAX_LINE_WIDTH = DEF_MAX_LINE
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [NUM_CH-1:0][SMP_W-1:0]  sample_i,
  input  logic [LW_W-1:0]               line_width_i,
  input  logic [FH_W-1:0]               frame_height_i,
  input  logic [$clog2(Q_DEPTH+1)-1:0]  q_count_i,
  output logic                          full_o,
  output logic                          item_valid_o,
  output grad_item_t                    item_o
);

  localparam int unsigned CW = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned WW = 14;

  logic [2*PIX_W-1:0]         mem_q [MAX_LINE_WIDTH];
  logic [2*PIX_W-1:0]         rd_q;
  logic [CW-1:0]              col_q, col_d;
  logic [ROW_W-1:0]           row_q, row_d;
  logic [WW-1:0]              w_cl, lw_ext;
  logic [FH_W-1:0]            h_cl;
  logic                       accept, emit, done;

  logic                       s1_v_q, s1_emit_q, s1_done_q;
  logic [CW-1:0]              s1_col_q;
  logic [ROW_W-1:0]           s1_orow_q;
  logic [COL_W-1:0]           s1_ocol_q;
  logic [PIX_W-1:0]           s1_smp_q;

  logic [SMP_W-1:0]           win_q [3][3][NUM_CH];
  logic [SMP_W-1:0]           win_d [3][3][NUM_CH];
  logic [NUM_CH-1:0][GRAD_W-1:0] gx_d, gy_d;

  logic                       s2_v_q;
  grad_item_t                 s2_q;

  logic [$clog2(Q_DEPTH+1):0] credit_use;

  assign credit_use = ($clog2(Q_DEPTH+1)+1)'(q_count_i)
                    + ($clog2(Q_DEPTH+1)+1)'(s1_v_q)
                    + ($clog2(Q_DEPTH+1)+1)'(s2_v_q);
  assign full_o = (credit_use >= ($clog2(Q_DEPTH+1)+1)'(Q_DEPTH));
  assign accept = push_i && !full_o;

  // Usable frame sizes after clamping.
  always_comb begin
    lw_ext = WW'(line_width_i);
    if (lw_ext < WW'(3)) begin
      w_cl = WW'(3);
    end else if (lw_ext > WW'(MAX_LINE_WIDTH)) begin
      w_cl = WW'(MAX_LINE_WIDTH);
    end else begin
      w_cl = lw_ext;
    end
    if (frame_height_i < FH_W'(3)) begin
      h_cl = FH_W'(3);
    end else if (frame_height_i > FH_W'(HEIGHT_LIMIT)) begin
      h_cl = FH_W'(HEIGHT_LIMIT);
    end else begin
      h_cl = frame_height_i;
    end
  end

  assign emit = (row_q >= ROW_W'(2)) && (WW'(col_q) >= WW'(2));
  assign done = ((FH_W'(row_q) + FH_W'(1)) >= h_cl) && ((WW'(col_q) + WW'(1)) >= w_cl);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if ((WW'(col_q) + WW'(1)) >= w_cl) begin
      col_d = '0;
      row_d = ((FH_W'(row_q) + FH_W'(1)) >= h_cl) ? '0 : row_q + ROW_W'(1);
    end else begin
      col_d = col_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q && s1_emit_q;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q      <= mem_q[col_q];
      s1_col_q  <= col_q;
      s1_emit_q <= emit;
      s1_done_q <= done;
      s1_orow_q <= row_q - ROW_W'(1);
      s1_ocol_q <= COL_W'(WW'(col_q) - WW'(1));
      s1_smp_q  <= sample_i;
    end
  end

  // The older row moves up and the new sample becomes the lower row.
  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      mem_q[s1_col_q] <= {rd_q[PIX_W-1:0], s1_smp_q};
    end
  end

  always_comb begin
    logic signed [GRAD_W:0] ax, ay;
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        win_d[k][0][c] = win_q[k][1][c];
        win_d[k][1][c] = win_q[k][2][c];
      end
    end
    for (int c = 0; c < NUM_CH; c++) begin
      win_d[0][2][c] = rd_q[PIX_W + c*SMP_W +: SMP_W];
      win_d[1][2][c] = rd_q[c*SMP_W +: SMP_W];
      win_d[2][2][c] = s1_smp_q[c*SMP_W +: SMP_W];
    end
    for (int c = 0; c < NUM_CH; c++) begin
      ax = $signed({4'b0, win_d[0][2][c]}) - $signed({4'b0, win_d[0][0][c]})
         + (($signed({4'b0, win_d[1][2][c]}) - $signed({4'b0, win_d[1][0][c]})) <<< 1)
         + $signed({4'b0, win_d[2][2][c]}) - $signed({4'b0, win_d[2][0][c]});
      ay = $signed({4'b0, win_d[2][0][c]}) - $signed({4'b0, win_d[0][0][c]})
         + (($signed({4'b0, win_d[2][1][c]}) - $signed({4'b0, win_d[0][1][c]})) <<< 1)
         + $signed({4'b0, win_d[2][2][c]}) - $signed({4'b0, win_d[0][2][c]});
      gx_d[c] = ax[GRAD_W-1:0];
      gy_d[c] = ay[GRAD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      win_q     <= win_d;
      s2_q.row  <= s1_orow_q;
      s2_q.col  <= s1_ocol_q;
      s2_q.done <= s1_done_q;
      s2_q.gx   <= gx_d;
      s2_q.gy   <= gy_d;
    end
  end

  assign item_valid_o = s2_v_q;
  assign item_o       = s2_q;

endmodule

@@ hw/rtl/sem_back.sv @@
// Back end: squared gradient sum and a two-stage saturating integer square root.
// Depends on sem_pkg; pops the gradient queue when the result queue has room.
module sem_back
  import sem_pkg::*;
#(
  parameter int unsigned CHANNEL_COUNT = DEF_CHANNELS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  grad_item_t                    q_item_i,
  input  logic [$clog2(O_DEPTH+1)-1:0]  out_count_i,
  output logic                          q_pop_o,
  output logic                          res_valid_o,
  output edge_item_t                    res_o
);

  typedef struct packed {
    logic [ROW_W-1:0]              row;
    logic [COL_W-1:0]              col;
    logic                          done;
    logic [NUM_CH-1:0]             sat;
    logic [NUM_CH-1:0][15:0]       val;
    logic [NUM_CH-1:0][7:0]        root;
  } sq_stage_t;

  logic                       v0_q, v1_q, v2_q;
  sq_stage_t                  b0_q, b1_q, b1_d;
  edge_item_t                 b2_q, b2_d;
  sq_stage_t                  b0_d;
  logic [$clog2(O_DEPTH+1):0] credit_use;

  assign credit_use = ($clog2(O_DEPTH+1)+1)'(out_count_i)
                    + ($clog2(O_DEPTH+1)+1)'(v0_q)
                    + ($clog2(O_DEPTH+1)+1)'(v1_q)
                    + ($clog2(O_DEPTH+1)+1)'(v2_q);
  assign q_pop_o = !q_empty_i && (credit_use < ($clog2(O_DEPTH+1)+1)'(O_DEPTH));

  always_comb begin
    logic signed [2*GRAD_W-1:0] sx, sy;
    logic [20:0] sum;
    b0_d.row  = q_item_i.row;
    b0_d.col  = q_item_i.col;
    b0_d.done = q_item_i.done;
    b0_d.root = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      sx = $signed(q_item_i.gx[c]) * $signed(q_item_i.gx[c]);
      sy = $signed(q_item_i.gy[c]) * $signed(q_item_i.gy[c]);
      sum = 21'(sx) + 21'(sy);
      b0_d.sat[c] = |sum[20:16];
      b0_d.val[c] = sum[15:0];
    end
  end

  always_comb begin
    logic [7:0] r;
    b1_d = b0_q;
    for (int c = 0; c < NUM_CH; c++) begin
      r = '0;
      for (int i = 7; i >= 4; i--) begin
        r = isq_step(r, 8'(1 << i), b0_q.val[c]);
      end
      b1_d.root[c] = r;
    end
  end

  always_comb begin
    logic [7:0] r;
    b2_d.row  = b1_q.row;
    b2_d.col  = b1_q.col;
    b2_d.done = b1_q.done;
    for (int c = 0; c < NUM_CH; c++) begin
      r = b1_q.root[c];
      for (int i = 3; i >= 0; i--) begin
        r = isq_step(r, 8'(1 << i), b1_q.val[c]);
      end
      if (c >= CHANNEL_COUNT) begin
        b2_d.mag[c] = '0;
      end else begin
        b2_d.mag[c] = b1_q.sat[c] ? EDGE_MAX : r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= q_pop_o;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      b0_q <= b0_d;
    end
    if (v0_q) begin
      b1_q <= b1_d;
    end
    if (v1_q) begin
      b2_q <= b2_d;
    end
  end

  assign res_valid_o = v2_q;
  assign res_o       = b2_q;

endmodule

@@ hw/rtl/sobel_edge_magnitude.sv @@
// Streaming 3x3 Sobel gradient magnitude over three-channel pixels in raster order.
// Depends on sem_pkg, sem_fifo, sem_front, sem_back and assert_macros.svh.
//
// Input channel: a queue interface. A pixel transfers on a clock edge with push high
// and full low. Result channel: the oldest result is on the out_* and edge_* ports
// while empty is low, and it transfers on an edge with pop high and empty low.
// Configuration: cfg_valid_i with cfg_index_i and cfg_data_i writes the line width
// (index 0) or the frame height (index 1); cfg_ready_o is always high. Write only
// while the block is idle.
// Only interior pixels produce a result; border pixels produce none.
// frame_done_o marks the last interior result of a frame.
// Throughput is one pixel per cycle while full is low: the front end, its line memory
// (one read and one write port) and the back-end square-root pipeline each take one
// item a cycle while credit allows. A result passes the registers s1, s2, the gradient
// queue, b0, b1, b2 and the result queue. When the receiver stalls, results collect in
// an eight-entry result queue and then in the gradient queue; full rises once the
// queue credit is used up and falls again once the back end pops the gradient queue.
// Reset clears the counters, the queues and the size registers (640 by 480). Line
// memory contents are not cleared; the first two rows of a frame are never emitted.
module sobel_edge_magnitude
  import sem_pkg::*;
#(
  parameter int unsigned MAX_LINE_WIDTH = DEF_MAX_LINE,
  parameter int unsigned CHANNEL_COUNT  = DEF_CHANNELS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [SMP_W-1:0]      sample_zero_i,
  input  logic [SMP_W-1:0]      sample_one_i,
  input  logic [SMP_W-1:0]      sample_two_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [ROW_W-1:0]      out_row_o,
  output logic [COL_W-1:0]      out_col_o,
  output logic [SMP_W-1:0]      edge_zero_o,
  output logic [SMP_W-1:0]      edge_one_o,
  output logic [SMP_W-1:0]      edge_two_o,
  output logic                  frame_done_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

`include "assert_macros.svh"

  logic [LW_W-1:0]              line_width_q;
  logic [FH_W-1:0]              frame_height_q;

  logic                         grad_valid;
  grad_item_t                   grad_item, q_item;
  logic                         q_empty, q_full, q_pop;
  logic [$clog2(Q_DEPTH+1)-1:0] q_count;

  logic                         res_valid;
  edge_item_t                   res_item, out_item;
  logic                         o_full;
  logic [$clog2(O_DEPTH+1)-1:0] o_count;

  assign cfg_ready_o = 1'b1;

  // Size registers; a write to an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= LW_RESET;
      frame_height_q <= FH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LINE_WIDTH:   line_width_q   <= cfg_data_i[LW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sem_front #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .sample_i       ({sample_two_i, sample_one_i, sample_zero_i}),
    .line_width_i   (line_width_q),
    .frame_height_i (frame_height_q),
    .q_count_i      (q_count),
    .full_o         (full),
    .item_valid_o   (grad_valid),
    .item_o         (grad_item)
  );

  sem_fifo #(
    .WIDTH($bits(grad_item_t)),
    .DEPTH(Q_DEPTH)
  ) u_grad_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (grad_valid),
    .data_i  (grad_item),
    .pop_i   (q_pop),
    .data_o  (q_item),
    .empty_o (q_empty),
    .full_o  (q_full),
    .count_o (q_count)
  );

  sem_back #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (q_item),
    .out_count_i (o_count),
    .q_pop_o     (q_pop),
    .res_valid_o (res_valid),
    .res_o       (res_item)
  );

  sem_fifo #(
    .WIDTH($bits(edge_item_t)),
    .DEPTH(O_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res_item),
    .pop_i   (pop),
    .data_o  (out_item),
    .empty_o (empty),
    .full_o  (o_full),
    .count_o (o_count)
  );

  assign out_row_o    = out_item.row;
  assign out_col_o    = out_item.col;
  assign frame_done_o = out_item.done;
  assign edge_zero_o  = out_item.mag[0];
  assign edge_one_o   = out_item.mag[1];
  assign edge_two_o   = out_item.mag[2];

  // Credit checks must keep both queues from overflow and the back end from empty pops.
  `SEM_ASSERT(a_grad_q_no_overflow, grad_valid |-> !q_full, "gradient queue overflow")
  `SEM_ASSERT(a_out_q_no_overflow, res_valid |-> !o_full, "result queue overflow")
  `SEM_ASSERT(a_back_pop_nonempty, q_pop |-> !q_empty, "back end popped an empty queue")

endmodule

@@ test/sobel_edge_checker.sv @@
// Checker for the Sobel edge magnitude block: watches the pixel, result and write channels.
// Depends on sem_pkg; instantiated by tb next to the block.
module sobel_edge_checker
  import sem_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  input  logic                  full,
  input  logic [SMP_W-1:0]      sample_zero_i,
  input  logic [SMP_W-1:0]      sample_one_i,
  input  logic [SMP_W-1:0]      sample_two_i,
  input  logic                  empty,
  input  logic                  pop,
  input  logic [ROW_W-1:0]      out_row_i,
  input  logic [COL_W-1:0]      out_col_i,
  input  logic [SMP_W-1:0]      edge_zero_i,
  input  logic [SMP_W-1:0]      edge_one_i,
  input  logic [SMP_W-1:0]      edge_two_i,
  input  logic                  frame_done_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [SMP_W-1:0] mag [3];
    logic             done;
  } edge_exp_t;

  edge_exp_t        edge_q[$];
  logic [LW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;
  logic [7:0]       row_above2 [1024][3];
  logic [7:0]       row_above1 [1024][3];
  logic [7:0]       win [3][3][3];
  int               row_pos;
  int               col_pos;
  int               fails;

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [7:0] sat_root(int v);
    int r;
    int t;
    r = 0;
    if (v >= 65536) return 8'd255;
    for (int b = 128; b != 0; b = b >> 1) begin
      t = r | b;
      if (t * t <= v) r = t;
    end
    return 8'(r);
  endfunction

  task automatic note_mismatch(string what, int exp_v, int act_v);
    if (fails < 10)
      $display("checker: %s mismatch, expected %0d, got %0d", what, exp_v, act_v);
    fails++;
  endtask

  // Advance the pixel pipeline by one transfer and queue the result it causes, if any.
  task automatic predict_pixel(logic [7:0] s0, logic [7:0] s1, logic [7:0] s2);
    int        w;
    int        h;
    int        gx;
    int        gy;
    logic [7:0] smp [3];
    edge_exp_t e;
    w = clampi(int'(width_reg), 3, 1024);
    h = clampi(int'(height_reg), 3, HEIGHT_LIMIT);
    smp[0] = s0; smp[1] = s1; smp[2] = s2;
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        win[k][0][c] = win[k][1][c];
        win[k][1][c] = win[k][2][c];
      end
      win[0][2][c] = row_above2[col_pos][c];
      win[1][2][c] = row_above1[col_pos][c];
      win[2][2][c] = smp[c];
      row_above2[col_pos][c] = row_above1[col_pos][c];
      row_above1[col_pos][c] = smp[c];
    end
    if (row_pos >= 2 && col_pos >= 2) begin
      e.row = ROW_W'(row_pos - 1);
      e.col = COL_W'(col_pos - 1);
      for (int c = 0; c < 3; c++) begin
        gx = 0;
        gy = 0;
        for (int k = 0; k < 3; k++)
          for (int l = 0; l < 3; l++) begin
            gx += int'(win[k][l][c]) * (l - 1) * ((k == 1) ? 2 : 1);
            gy += int'(win[k][l][c]) * (k - 1) * ((l == 1) ? 2 : 1);
          end
        e.mag[c] = sat_root(gx * gx + gy * gy);
      end
      e.done = (row_pos + 1 >= h) && (col_pos + 1 >= w);
      edge_q.push_back(e);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    edge_exp_t e;
    if (!rst_ni) begin
      width_reg  = LW_RESET;
      height_reg = FH_RESET;
      row_pos    = 0;
      col_pos    = 0;
      fails      = 0;
      edge_q.delete();
      for (int i = 0; i < 1024; i++)
        for (int c = 0; c < 3; c++) begin
          row_above2[i][c] = '0;
          row_above1[i][c] = '0;
        end
      for (int k = 0; k < 3; k++)
        for (int l = 0; l < 3; l++)
          for (int c = 0; c < 3; c++) win[k][l][c] = '0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_LINE_WIDTH) width_reg = LW_W'(cfg_data_i);
        else if (cfg_index_i == CFG_FRAME_HEIGHT) height_reg = FH_W'(cfg_data_i);
      end
      if (push && !full) predict_pixel(sample_zero_i, sample_one_i, sample_two_i);
      if (pop && !empty) begin
        if (edge_q.size() == 0) begin
          if (fails < 10) $display("checker: result with nothing expected");
          fails++;
        end else begin
          e = edge_q.pop_front();
          if (out_row_i !== e.row) note_mismatch("out_row", e.row, out_row_i);
          if (out_col_i !== e.col) note_mismatch("out_col", e.col, out_col_i);
          if (edge_zero_i !== e.mag[0]) note_mismatch("edge_zero", e.mag[0], edge_zero_i);
          if (edge_one_i !== e.mag[1]) note_mismatch("edge_one", e.mag[1], edge_one_i);
          if (edge_two_i !== e.mag[2]) note_mismatch("edge_two", e.mag[2], edge_two_i);
          if (frame_done_i !== e.done) note_mismatch("frame_done", e.done, frame_done_i);
        end
      end
      fail_count_o <= fails;
      pending_o    <= edge_q.size();
    end
  end

endmodule

@@ test/tb.sv @@
// Top of the Sobel edge magnitude testbench: clock, reset, pixel frames and the verdict.
// Depends on sem_pkg, sobel_edge_magnitude and sobel_edge_checker.
module tb;
  import sem_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic [SMP_W-1:0]      sample_zero_i;
  logic [SMP_W-1:0]      sample_one_i;
  logic [SMP_W-1:0]      sample_two_i;
  logic                  empty;
  logic                  pop;
  logic [ROW_W-1:0]      out_row_o;
  logic [COL_W-1:0]      out_col_o;
  logic [SMP_W-1:0]      edge_zero_o;
  logic [SMP_W-1:0]      edge_one_o;
  logic [SMP_W-1:0]      edge_two_o;
  logic                  frame_done_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    fail_count;
  int                    pending;
  int                    cycles;

  // Idle mode: 0 none, 1 sender gaps, 2 receiver stalls, 3 both.
  int                    idle_mode;
  int                    send_gap_pct;
  int                    pop_stall_pct;
  int                    random_pixels;

  sobel_edge_magnitude DUT (
    .clk_i, .rst_ni, .push, .full, .sample_zero_i, .sample_one_i, .sample_two_i,
    .empty, .pop, .out_row_o, .out_col_o, .edge_zero_o, .edge_one_o, .edge_two_o,
    .frame_done_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  sobel_edge_checker u_checker (
    .clk_i, .rst_ni, .push, .full, .sample_zero_i, .sample_one_i, .sample_two_i,
    .empty, .pop, .out_row_i(out_row_o), .out_col_i(out_col_o), .edge_zero_i(edge_zero_o),
    .edge_one_i(edge_one_o), .edge_two_i(edge_two_o), .frame_done_i(frame_done_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // The watchdog ends a run that hangs on a handshake.
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  always_comb begin
    send_gap_pct  = (idle_mode == 1) ? 47 : ((idle_mode == 3) ? 38 : 0);
    pop_stall_pct = (idle_mode == 2) ? 47 : ((idle_mode == 3) ? 38 : 0);
  end

  // The receiver pops at random according to the current idle mode.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    end
  end

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // One register write; the block is idle whenever this is called.
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Present one pixel, with an optional gap first, and return at the edge of its transfer.
  task automatic send_pixel(logic [7:0] s0, logic [7:0] s1, logic [7:0] s2);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    push          <= 1'b1;
    sample_zero_i <= s0;
    sample_one_i  <= s1;
    sample_two_i  <= s2;
    do @(posedge clk_i); while (full);
  endtask

  // Send a whole frame. Pattern 0 is random, 1 a bright left column, 2 a checkerboard of
  // extremes, 3 a flat field, white in channel zero.
  task automatic send_frame(int w, int h, int pattern);
    logic [7:0] v;
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        case (pattern)
          1: v = (c == 0) ? 8'd255 : 8'd0;
          2: v = ((r + c) % 2 == 1) ? 8'd255 : 8'd0;
          3: v = 8'd255;
          default: v = 8'($urandom);
        endcase
        if (pattern == 0) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        else send_pixel(v, ~v, (pattern == 2) ? v : 8'd0);
        if (pattern == 0) random_pixels++;
      end
    push <= 1'b0;
  endtask

  // Wait until every expected result has been popped, then let the pipeline drain.
  // The first edge lets the checker count the last pixel before pending is read.
  task automatic drain;
    @(posedge clk_i);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Set both sizes from raw register values and send one frame at the resulting size.
  task automatic run_frame(logic [CFG_DATA_W-1:0] wr, logic [CFG_DATA_W-1:0] hr,
                           int pattern);
    drain();
    write_reg(CFG_LINE_WIDTH, wr);
    write_reg(CFG_FRAME_HEIGHT, hr);
    send_frame(clampi(int'(wr & 13'h7FF), 3, 1024), clampi(int'(hr), 3, HEIGHT_LIMIT),
               pattern);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] wr;
    logic [CFG_DATA_W-1:0] hr;
    rst_ni        = 1'b0;
    push          = 1'b0;
    sample_zero_i = '0;
    sample_one_i  = '0;
    sample_two_i  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_LINE_WIDTH;
    cfg_data_i    = '0;
    idle_mode     = 0;
    random_pixels = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames at the smallest size; the raw values below three are clamped.
    run_frame(13'd0, 13'd2, 1);
    run_frame(13'd1, 13'd0, 2);
    run_frame(13'd2, 13'd1, 3);

    // Wider and taller frames; the first width carries upper bits that the register drops.
    idle_mode = 3;
    run_frame(13'h1840, 13'd4, 0);
    idle_mode = 2;
    run_frame(13'd4, 13'd40, 0);
    idle_mode = 1;
    run_frame(13'd40, 13'd3, 2);
    idle_mode = 0;
    run_frame(13'd100, 13'd3, 0);

    // Random small frames under every idle mode.
    random_pixels = 0;
    while (random_pixels < 450) begin
      idle_mode = $urandom_range(0, 3);
      wr = 13'($urandom_range(3, 24));
      hr = 13'($urandom_range(3, 8));
      if ($urandom_range(0, 9) == 0) wr = 13'($urandom_range(0, 2));
      run_frame(wr, hr, 0);
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
